### design/sil_pkg.sv
// Shared types and status codes for the sorted insertion list.
package sil_pkg;

    localparam int DATA_W = 32;

    typedef logic [1:0]               t_status;
    typedef logic signed [DATA_W-1:0] t_value;

    // Result status codes
    localparam t_status ST_ENTRY = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    // Input action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DUMP   = 1'b1;

endpackage

### design/sil_stream_if.sv
// Valid/ready stream interfaces for the command and result channels.
interface sil_in_if;
    import sil_pkg::*;

    logic   valid;
    logic   ready;
    logic   action;
    t_value value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface sil_out_if;
    import sil_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_value  entry_value;
    logic    last;

    modport source (output valid, output status, output entry_value, output last,
                    input ready);
    modport sink   (input valid, input status, input entry_value, input last,
                    output ready);
endinterface

### design/sil_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
module sil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/sorted_insertion_list_unit.sv
// Top level: bounded ascending list with insert and in-order dump.
//
//  channel  | dir | beat fields                        | role
//  ---------+-----+------------------------------------+-------------------------------
//  i_in     | in  | action, value                      | insert a value or dump the list
//  o_out    | out | status, entry_value, last          | dumped entries, full/empty marks
//
// An insert walks the list down from the top: one compare and shift step per entry until
// a smaller entry turns up, plus a final write when the new value is the smallest; the walk
// moves one entry per cycle, set by the single read port of the entry RAM. A dump reads
// each entry from the RAM, then loads it into the output register; full and empty marks
// are loaded into the output register once it is free. Reset empties
// the list by clearing the entry count; the RAM itself is not cleared. A stalled output
// holds its beat and the sequencer waits; no new beat is accepted until the item is done.
module sorted_insertion_list_unit #(
    parameter int CAPACITY = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sil_in_if.sink   i_in,
    sil_out_if.source o_out
);
    import sil_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISTEP = 3'd1;
    localparam logic [2:0] S_IWR0  = 3'd2;
    localparam logic [2:0] S_DREQ  = 3'd3;
    localparam logic [2:0] S_DOUT  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx,   n_idx;
    t_value        r_val,   n_val;
    t_status       r_pend,  n_pend;

    logic          r_out_valid, n_out_valid;
    t_status       r_out_status, n_out_status;
    t_value        r_out_value,  n_out_value;
    logic          r_out_last,   n_out_last;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_value        ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    t_value        rd_val;

    logic          in_beat;
    logic          slot_free;
    logic          is_full;
    logic [AW-1:0] idx_up;
    logic [AW-1:0] idx_dn;
    logic [AW-1:0] top_idx;

    sil_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_val    = $signed(ram_rdata);
    assign in_beat   = i_in.valid & i_in.ready;
    assign slot_free = ~r_out_valid | o_out.ready;
    assign is_full   = (r_count == CW'(CAPACITY));
    assign idx_up    = AW'(r_idx + AW'(1));
    assign idx_dn    = AW'(r_idx - AW'(1));
    assign top_idx   = AW'(r_count - CW'(1));

    assign i_in.ready = (r_state == S_IDLE);

    // read address: top entry on accept, next lower during the walk, cursor on dump
    always_comb begin
        case (r_state)
            S_IDLE:  ram_raddr = top_idx;
            S_ISTEP: ram_raddr = idx_dn;
            default: ram_raddr = r_idx;
        endcase
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_val        = r_val;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid & ~o_out.ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = idx_up;
        ram_wdata    = r_val;

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_val = i_in.value;
                    n_idx = top_idx;
                    if (i_in.action == ACT_INSERT) begin
                        if (is_full) begin
                            n_pend  = ST_FULL;
                            n_state = S_EMIT;
                        end else if (r_count == '0) begin
                            n_state = S_IWR0;
                        end else begin
                            n_state = S_ISTEP;
                        end
                    end else begin
                        n_idx = '0;
                        if (r_count == '0) begin
                            n_pend  = ST_EMPTY;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_DREQ;
                        end
                    end
                end
            end

            // compare entry at r_idx; shift it up or drop the new value above it
            S_ISTEP: begin
                ram_we = 1'b1;
                if (rd_val < r_val) begin
                    ram_wdata = r_val;
                    n_count   = CW'(r_count + CW'(1));
                    n_state   = S_IDLE;
                end else begin
                    ram_wdata = rd_val;
                    if (r_idx == '0) begin
                        n_state = S_IWR0;
                    end else begin
                        n_idx = idx_dn;
                    end
                end
            end

            // new value is the smallest
            S_IWR0: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = r_val;
                n_count   = CW'(r_count + CW'(1));
                n_state   = S_IDLE;
            end

            // read latency slot for the dump cursor
            S_DREQ: begin
                n_state = S_DOUT;
            end

            S_DOUT: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_ENTRY;
                    n_out_value  = rd_val;
                    if ((CW'(r_idx) + CW'(1)) == r_count) begin
                        n_out_last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_out_last = 1'b0;
                        n_idx      = idx_up;
                        n_state    = S_DREQ;
                    end
                end
            end

            // single full or empty mark
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_pend;
                    n_out_value  = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_val        <= n_val;
        r_pend       <= n_pend;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.entry_value = r_out_value;
    assign o_out.last        = r_out_last;

endmodule

### bench/testbench.sv
// Self-checking bench for the sorted insertion list: directed table, then random beats.
module testbench;
    import sil_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int RAND_ITEMS  = 380;
    localparam int DRAIN_WAIT  = 2 * CAPACITY + 20;
    localparam int CYCLE_LIMIT = 800000;

    // One expected output beat
    typedef struct {
        t_status status;
        t_value  entry_value;
        logic    is_last;
    } t_list_beat;

    // One row of the directed table; fixed rows carry their single result inline
    typedef struct {
        logic    action;
        t_value  value;
        bit      fixed;
        t_status fixed_status;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    sil_in_if  in_bus ();
    sil_out_if out_bus ();

    sorted_insertion_list_unit #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    t_value     sorted_vals[$];
    t_list_beat pending_beats[$];
    int         fail_count = 0;
    int         cycle_count = 0;
    int         burst_left = 0;

    // Receiver stall pattern state
    int         rx_mode = 0;
    int         rx_mode_left = 0;
    int         rx_stall_left = 0;
    int         rx_tick = 0;

    t_dir_row   dir_rows[24];

    // Clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Known values on every input from time zero
    initial begin
        i_rst_n         = 1'b0;
        in_bus.valid    = 1'b0;
        in_bus.action   = ACT_INSERT;
        in_bus.value    = '0;
        out_bus.ready   = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at %0t with %0d beats outstanding", $time,
                     pending_beats.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Update the list copy for one accepted beat; queue its results when asked
    function automatic void apply_list_op(input logic act, input t_value val,
                                          input bit queue_results);
        t_list_beat b;
        int pos;
        begin
            if (act == ACT_INSERT) begin
                if (sorted_vals.size() >= CAPACITY) begin
                    b = '{ST_FULL, '0, 1'b1};
                    if (queue_results) pending_beats.push_back(b);
                end else begin
                    // new value goes ahead of all equal entries
                    pos = 0;
                    while (pos < sorted_vals.size() && sorted_vals[pos] < val)
                        pos++;
                    sorted_vals.insert(pos, val);
                end
            end else if (sorted_vals.size() == 0) begin
                b = '{ST_EMPTY, '0, 1'b1};
                if (queue_results) pending_beats.push_back(b);
            end else begin
                for (int i = 0; i < sorted_vals.size(); i++) begin
                    b = '{ST_ENTRY, sorted_vals[i], (i == sorted_vals.size() - 1)};
                    if (queue_results) pending_beats.push_back(b);
                end
            end
        end
    endfunction

    // Send one beat, opening a new burst after a random gap when the last one ran out
    task automatic issue_beat(input logic act, input t_value val, input bit fixed,
                              input t_status fixed_status);
        int gap;
        t_list_beat b;
        begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                repeat (gap) begin
                    @(negedge i_clk);
                    in_bus.valid <= 1'b0;
                end
                burst_left = $urandom_range(1, 12);
            end
            @(negedge i_clk);
            in_bus.valid  <= 1'b1;
            in_bus.action <= act;
            in_bus.value  <= val;
            do @(posedge i_clk); while (!in_bus.ready);
            burst_left--;
            if (fixed) begin
                apply_list_op(act, val, 1'b0);
                b = '{fixed_status, '0, 1'b1};
                pending_beats.push_back(b);
            end else begin
                apply_list_op(act, val, 1'b1);
            end
        end
    endtask

    function automatic t_dir_row dir_row(input logic act, input t_value val,
                                         input bit fixed, input t_status st);
        t_dir_row r;
        begin
            r.action       = act;
            r.value        = val;
            r.fixed        = fixed;
            r.fixed_status = st;
            return r;
        end
    endfunction

    // Receiver: ready pattern switches between always-on, coin flip, sparse and long stalls
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(20, 80);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            0: out_bus.ready <= 1'b1;
            1: out_bus.ready <= 1'($urandom_range(0, 1));
            2: out_bus.ready <= (rx_tick % 4 == 0);
            default: begin
                if (rx_stall_left > 0) begin
                    out_bus.ready <= 1'b0;
                    rx_stall_left <= rx_stall_left - 1;
                end else begin
                    out_bus.ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        rx_stall_left <= $urandom_range(5, 20);
                end
            end
        endcase
    end

    // Result checker
    always @(posedge i_clk) begin
        t_list_beat want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_beats.size() == 0) begin
                $display("%0t unexpected beat: status %0d value %0d last %0b", $time,
                         out_bus.status, out_bus.entry_value, out_bus.last);
                fail_count++;
            end else begin
                want = pending_beats.pop_front();
                if (out_bus.status !== want.status) begin
                    $display("%0t status mismatch: expected %0d actual %0d", $time,
                             want.status, out_bus.status);
                    fail_count++;
                end
                if (out_bus.entry_value !== want.entry_value) begin
                    $display("%0t entry_value mismatch: expected %0d actual %0d", $time,
                             want.entry_value, out_bus.entry_value);
                    fail_count++;
                end
                if (out_bus.last !== want.is_last) begin
                    $display("%0t last mismatch: expected %0b actual %0b", $time,
                             want.is_last, out_bus.last);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        logic   act;
        t_value val;

        // extremes, equal values, an empty dump and inserts into a full list
        dir_rows[0]  = dir_row(ACT_DUMP,   32'sd0,         1'b1, ST_EMPTY);
        dir_rows[1]  = dir_row(ACT_INSERT, 32'sd0,         1'b0, ST_ENTRY);
        dir_rows[2]  = dir_row(ACT_INSERT, 32'h8000_0000,  1'b0, ST_ENTRY);
        dir_rows[3]  = dir_row(ACT_INSERT, 32'h7fff_ffff,  1'b0, ST_ENTRY);
        dir_rows[4]  = dir_row(ACT_INSERT, -32'sd1,        1'b0, ST_ENTRY);
        dir_rows[5]  = dir_row(ACT_INSERT, 32'sd0,         1'b0, ST_ENTRY);
        dir_rows[6]  = dir_row(ACT_DUMP,   32'hffff_ffff,  1'b0, ST_ENTRY);
        dir_rows[7]  = dir_row(ACT_INSERT, 32'h8000_0000,  1'b0, ST_ENTRY);
        dir_rows[8]  = dir_row(ACT_INSERT, 32'h7fff_ffff,  1'b0, ST_ENTRY);
        dir_rows[9]  = dir_row(ACT_INSERT, 32'sd1,         1'b0, ST_ENTRY);
        dir_rows[10] = dir_row(ACT_INSERT, 32'h5555_5555,  1'b0, ST_ENTRY);
        dir_rows[11] = dir_row(ACT_INSERT, 32'haaaa_aaaa,  1'b0, ST_ENTRY);
        dir_rows[12] = dir_row(ACT_INSERT, 32'h8000_0001,  1'b0, ST_ENTRY);
        dir_rows[13] = dir_row(ACT_INSERT, 32'h7fff_fffe,  1'b0, ST_ENTRY);
        dir_rows[14] = dir_row(ACT_INSERT, -32'sd2,        1'b0, ST_ENTRY);
        dir_rows[15] = dir_row(ACT_INSERT, 32'sd0,         1'b0, ST_ENTRY);
        dir_rows[16] = dir_row(ACT_DUMP,   32'sd0,         1'b0, ST_ENTRY);
        dir_rows[17] = dir_row(ACT_INSERT, 32'sd100,       1'b0, ST_ENTRY);
        dir_rows[18] = dir_row(ACT_INSERT, -32'sd100,      1'b0, ST_ENTRY);
        dir_rows[19] = dir_row(ACT_INSERT, 32'sd12345,     1'b1, ST_FULL);
        dir_rows[20] = dir_row(ACT_INSERT, 32'h7fff_ffff,  1'b1, ST_FULL);
        dir_rows[21] = dir_row(ACT_DUMP,   32'h8000_0000,  1'b0, ST_ENTRY);
        dir_rows[22] = dir_row(ACT_INSERT, 32'h8000_0000,  1'b1, ST_FULL);
        dir_rows[23] = dir_row(ACT_DUMP,   32'h7fff_ffff,  1'b0, ST_ENTRY);

        // synchronous reset, released on a falling clock edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            issue_beat(dir_rows[i].action, dir_rows[i].value, dir_rows[i].fixed,
                       dir_rows[i].fixed_status);

        // random beats; the list is full by now, so inserts hit the drop path
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 2) begin
                // drop valid, then hold off until every expected beat has come back
                @(negedge i_clk);
                in_bus.valid <= 1'b0;
                while (pending_beats.size() != 0) @(posedge i_clk);
                repeat (CAPACITY + 4) begin
                    @(negedge i_clk);
                    in_bus.valid <= 1'b0;
                end
                burst_left = 0;
            end
            act = ($urandom_range(0, 99) < 55) ? ACT_DUMP : ACT_INSERT;
            case ($urandom_range(0, 7))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7fff_ffff;
                default: val = $urandom;
            endcase
            issue_beat(act, val, 1'b0, ST_ENTRY);
        end

        @(negedge i_clk);
        in_bus.valid <= 1'b0;

        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0 && pending_beats.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
